>>> sv/mlce_pkg.sv
// Shared types and constants for the belt motor link command engine.
// Depends on nothing; the top level refers to it by scoped names.
package mlce_pkg;

  // Sequencer phases. The encoding follows the order of the drive sequence.
  typedef enum logic [3:0] {
    PH_IDLE_START = 4'd0,
    PH_IDLE_WAIT  = 4'd1,
    PH_SEND_BACK  = 4'd2,
    PH_WAIT_BACK  = 4'd3,
    PH_SEND_STOP  = 4'd4,
    PH_WAIT_STOP  = 4'd5,
    PH_SEND_POLL  = 4'd6,
    PH_WAIT_POLL  = 4'd7,
    PH_SEND_FWD   = 4'd8,
    PH_WAIT_FWD   = 4'd9,
    PH_SEND_SPEED = 4'd10,
    PH_WAIT_SPEED = 4'd11
  } phase_t;

  // Request codes carried in the cmd field.
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_BACK  = 3'd1;
  localparam logic [2:0] CMD_FWD   = 3'd2;
  localparam logic [2:0] CMD_STOP  = 3'd3;
  localparam logic [2:0] CMD_SPEED = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_SPEED_SETTING = 2'd0;
  localparam logic [1:0] REG_POLL_INTERVAL = 2'd1;
  localparam logic [1:0] REG_REPLY_WAIT    = 2'd2;
  localparam logic [1:0] REG_RETRY_LIMIT   = 2'd3;

  // Frame bytes and reply codes.
  localparam logic [7:0]  DRIVE_HEADER = 8'h85;
  localparam logic [7:0]  REPLY_HEADER = 8'h99;
  localparam logic [7:0]  DIR_BACK     = 8'h01;
  localparam logic [7:0]  DIR_FWD      = 8'h41;
  localparam logic [7:0]  SPEED_MAX    = 8'd127;
  localparam logic [7:0]  STATUS_OK    = 8'h00;
  localparam logic [7:0]  STATUS_IDLE  = 8'h10;
  localparam logic [7:0]  ERR_NONE     = 8'h00;
  localparam logic [7:0]  ERR_OVERCUR  = 8'h01;
  localparam logic [7:0]  ERR_HALL     = 8'h05;
  localparam logic [7:0]  ERR_OTHER    = 8'h80;
  localparam logic [7:0]  ERR_NO_REPLY = 8'hFF;
  localparam logic [63:0] RUN_FRAME    = 64'h0001_0000_0000_018A;

  // Reset values of the registers and the frame state.
  localparam logic [15:0] POLL_INTERVAL_RST = 16'd1000;
  localparam logic [15:0] REPLY_WAIT_RST    = 16'd50;
  localparam logic [3:0]  RETRY_LIMIT_RST   = 4'd2;
  localparam logic [7:0]  DIRECTION_RST     = 8'h01;
  localparam logic [7:0]  SPEED_RST         = 8'h53;

  // Reciprocal of ten for a 16-bit dividend: (x * 0xCCCD) >> 19 is x / 10.
  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int          DIV10_SHIFT = 19;

endpackage

>>> sv/motor_link_command_engine.sv
// Top level of the belt motor link command engine: sequencer, frame builder
// and reply checker. Depends on mlce_pkg for phases, codes and constants.
//
// One transaction on the input stream is one system tick and yields exactly one
// result transaction. The whole state step (command override, wait counting with
// two 16-bit compares, reply XOR check, status mapping and frame assembly) runs
// in one pass from the accepted input into the output register, so a new tick is
// taken in every cycle while the output side keeps up. The result register holds
// one tick; when it is full and not being taken, the input is stalled. The speed
// byte comes from one 16x16 reciprocal multiply by one tenth on the speed
// setting register.
module motor_link_command_engine (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // Input stream, one transaction per tick
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: cmd[2:0], rx_count[10:3], rx_byte0[18:11], rx_byte1[26:19],
  //           rx_byte2[34:27], rx_byte3[42:35], zero fill [47:43]
  input  logic [47:0] in_tdata,
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: tx_valid[0], tx_frame[64:1], rx_clear[65], link_error[73:66],
  //            zero fill [79:74]
  output logic [79:0] out_tdata
);

  // Configuration registers
  logic [15:0] speed_setting_r;
  logic [15:0] poll_interval_r;
  logic [15:0] reply_wait_r;
  logic [3:0]  retry_limit_r;

  // Sequencer state
  mlce_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] wait_count_r, wait_count_nxt;
  logic [3:0]  retry_count_r, retry_count_nxt;
  logic [7:0]  direction_r, direction_nxt;
  logic [7:0]  fspeed_r, fspeed_nxt;
  logic [7:0]  error_code_r, error_code_nxt;

  // Result register
  logic        out_valid_r;
  logic [79:0] out_data_r;
  logic [79:0] out_data_nxt;

  // Unpacked input fields
  logic [2:0]  cmd;
  logic [7:0]  rx_count;
  logic [7:0]  rx_byte0, rx_byte1, rx_byte2, rx_byte3;

  // Datapath helpers
  logic        in_fire;
  logic [31:0] div_prod;
  logic [12:0] speed_div;
  logic [7:0]  speed_byte;
  logic        reply_valid;
  logic        status_ok;
  logic [7:0]  status_err;
  logic        done_poll;
  logic        done_reply;
  logic        tx_valid;
  logic [63:0] tx_frame;
  logic        rx_clear;
  mlce_pkg::phase_t phase_cur;

  assign cmd      = in_tdata[2:0];
  assign rx_count = in_tdata[10:3];
  assign rx_byte0 = in_tdata[18:11];
  assign rx_byte1 = in_tdata[26:19];
  assign rx_byte2 = in_tdata[34:27];
  assign rx_byte3 = in_tdata[42:35];

  // Handshake: the result register frees itself when it is taken.
  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Speed byte: setting divided by ten, saturated at the frame maximum.
  assign div_prod   = speed_setting_r * mlce_pkg::DIV10_MUL;
  assign speed_div  = div_prod[31:mlce_pkg::DIV10_SHIFT];
  assign speed_byte = (speed_div > 13'(mlce_pkg::SPEED_MAX)) ? mlce_pkg::SPEED_MAX
                                                             : speed_div[7:0];

  // Reply check and status mapping.
  assign reply_valid = (rx_byte0 == mlce_pkg::REPLY_HEADER) &&
                       (rx_byte3 == (rx_byte1 ^ rx_byte2));
  assign status_ok   = (rx_byte2 == mlce_pkg::STATUS_OK) ||
                       (rx_byte2 == mlce_pkg::STATUS_IDLE);

  always_comb begin
    if (rx_byte2[0]) begin
      status_err = mlce_pkg::ERR_OVERCUR;
    end else if (rx_byte2[1]) begin
      status_err = mlce_pkg::ERR_HALL;
    end else begin
      status_err = mlce_pkg::ERR_OTHER | rx_byte2;
    end
  end

  // Wait phases end once the count has reached the limit.
  assign done_poll  = (wait_count_r >= poll_interval_r);
  assign done_reply = (wait_count_r >= reply_wait_r);

  // Sequencer step for one tick.
  always_comb begin
    phase_cur       = phase_r;
    retry_count_nxt = retry_count_r;
    wait_count_nxt  = wait_count_r;
    direction_nxt   = direction_r;
    fspeed_nxt      = fspeed_r;
    error_code_nxt  = error_code_r;
    tx_valid        = 1'b0;
    tx_frame        = '0;
    rx_clear        = 1'b0;

    // A request overrides whatever the sequence is doing.
    unique case (cmd)
      mlce_pkg::CMD_BACK: begin
        phase_cur       = mlce_pkg::PH_SEND_BACK;
        retry_count_nxt = '0;
      end
      mlce_pkg::CMD_FWD: begin
        phase_cur       = mlce_pkg::PH_SEND_FWD;
        retry_count_nxt = '0;
      end
      mlce_pkg::CMD_STOP: begin
        phase_cur       = mlce_pkg::PH_SEND_STOP;
        retry_count_nxt = '0;
      end
      mlce_pkg::CMD_SPEED: begin
        phase_cur       = mlce_pkg::PH_SEND_SPEED;
        retry_count_nxt = '0;
      end
      default: begin
      end
    endcase

    phase_nxt = phase_cur;

    unique case (phase_cur)
      mlce_pkg::PH_IDLE_START: begin
        wait_count_nxt = '0;
        phase_nxt      = mlce_pkg::PH_IDLE_WAIT;
      end

      mlce_pkg::PH_IDLE_WAIT: begin
        if (done_poll) begin
          phase_nxt = mlce_pkg::PH_SEND_POLL;
        end else begin
          wait_count_nxt = wait_count_r + 16'd1;
        end
      end

      mlce_pkg::PH_SEND_BACK, mlce_pkg::PH_SEND_FWD, mlce_pkg::PH_SEND_STOP,
      mlce_pkg::PH_SEND_SPEED, mlce_pkg::PH_SEND_POLL: begin
        unique case (phase_cur)
          mlce_pkg::PH_SEND_BACK: begin
            direction_nxt = mlce_pkg::DIR_BACK;
            fspeed_nxt    = speed_byte;
            phase_nxt     = mlce_pkg::PH_WAIT_BACK;
          end
          mlce_pkg::PH_SEND_FWD: begin
            direction_nxt = mlce_pkg::DIR_FWD;
            fspeed_nxt    = speed_byte;
            phase_nxt     = mlce_pkg::PH_WAIT_FWD;
          end
          mlce_pkg::PH_SEND_STOP: begin
            fspeed_nxt = '0;
            phase_nxt  = mlce_pkg::PH_WAIT_STOP;
          end
          mlce_pkg::PH_SEND_SPEED: begin
            fspeed_nxt = speed_byte;
            phase_nxt  = mlce_pkg::PH_WAIT_SPEED;
          end
          default: begin
            phase_nxt = mlce_pkg::PH_WAIT_POLL;
          end
        endcase
        tx_frame       = {direction_nxt ^ fspeed_nxt, 32'h0, fspeed_nxt, direction_nxt,
                          mlce_pkg::DRIVE_HEADER};
        tx_valid       = 1'b1;
        rx_clear       = 1'b1;
        wait_count_nxt = '0;
      end

      mlce_pkg::PH_WAIT_POLL: begin
        if (done_reply) begin
          if (rx_count >= 8'd4) begin
            if (reply_valid) begin
              error_code_nxt = status_ok ? mlce_pkg::ERR_NONE : status_err;
            end
          end else begin
            error_code_nxt = mlce_pkg::ERR_NO_REPLY;
          end
          phase_nxt = mlce_pkg::PH_IDLE_START;
        end else begin
          wait_count_nxt = wait_count_r + 16'd1;
        end
      end

      mlce_pkg::PH_WAIT_BACK, mlce_pkg::PH_WAIT_FWD, mlce_pkg::PH_WAIT_STOP,
      mlce_pkg::PH_WAIT_SPEED: begin
        if (done_reply) begin
          if (rx_count == 8'd4) begin
            // A proper reply: map a fault, or start the run on a good status unless it was a speed command.
            if (reply_valid) begin
              if (!status_ok) begin
                error_code_nxt = status_err;
              end else if (phase_cur != mlce_pkg::PH_WAIT_SPEED) begin
                tx_valid = 1'b1;
                tx_frame = mlce_pkg::RUN_FRAME;
              end
            end
            phase_nxt = mlce_pkg::PH_IDLE_START;
          end else if (retry_count_r < retry_limit_r) begin
            // No proper reply: send the same command again next tick.
            retry_count_nxt = retry_count_r + 4'd1;
            unique case (phase_cur)
              mlce_pkg::PH_WAIT_BACK: phase_nxt = mlce_pkg::PH_SEND_BACK;
              mlce_pkg::PH_WAIT_FWD:  phase_nxt = mlce_pkg::PH_SEND_FWD;
              mlce_pkg::PH_WAIT_STOP: phase_nxt = mlce_pkg::PH_SEND_STOP;
              default:                phase_nxt = mlce_pkg::PH_SEND_SPEED;
            endcase
          end else begin
            // Retries used up: fall back to the run frame, except after a speed command.
            phase_nxt = mlce_pkg::PH_IDLE_START;
            if (phase_cur != mlce_pkg::PH_WAIT_SPEED) begin
              tx_valid = 1'b1;
              tx_frame = mlce_pkg::RUN_FRAME;
            end
          end
        end else begin
          wait_count_nxt = wait_count_r + 16'd1;
        end
      end

      default: begin
        phase_nxt = mlce_pkg::PH_IDLE_START;
      end
    endcase

    out_data_nxt = {6'b0, error_code_nxt, rx_clear, tx_frame, tx_valid};
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_setting_r <= '0;
      poll_interval_r <= mlce_pkg::POLL_INTERVAL_RST;
      reply_wait_r    <= mlce_pkg::REPLY_WAIT_RST;
      retry_limit_r   <= mlce_pkg::RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mlce_pkg::REG_SPEED_SETTING: speed_setting_r <= cfg_wdata;
        mlce_pkg::REG_POLL_INTERVAL: poll_interval_r <= cfg_wdata;
        mlce_pkg::REG_REPLY_WAIT:    reply_wait_r    <= cfg_wdata;
        mlce_pkg::REG_RETRY_LIMIT:   retry_limit_r   <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state advances once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= mlce_pkg::PH_IDLE_START;
      wait_count_r  <= '0;
      retry_count_r <= '0;
      direction_r   <= mlce_pkg::DIRECTION_RST;
      fspeed_r      <= mlce_pkg::SPEED_RST;
      error_code_r  <= mlce_pkg::ERR_NONE;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      wait_count_r  <= wait_count_nxt;
      retry_count_r <= retry_count_nxt;
      direction_r   <= direction_nxt;
      fspeed_r      <= fspeed_nxt;
      error_code_r  <= error_code_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

>>> test/motor_link_checker.sv
// Checker for the belt motor link command engine: watches the configuration
// port and both streams, predicts every result and compares it field by field.
// Depends on mlce_pkg for phases, request codes, register indexes and constants.
module motor_link_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  output int          failures,
  output int          outstanding
);

  localparam int         MAX_REPORTS = 10;
  localparam logic [7:0] REPLY_LEN   = 8'd4;

  // One tick as carried in in_tdata, lowest field last.
  typedef struct packed {
    logic [7:0] byte3;
    logic [7:0] byte2;
    logic [7:0] byte1;
    logic [7:0] byte0;
    logic [7:0] count;
    logic [2:0] cmd;
  } link_tick_t;

  // One result as carried in out_tdata, lowest field last.
  typedef struct packed {
    logic [7:0]  link_error;
    logic        rx_clear;
    logic [63:0] tx_frame;
    logic        tx_valid;
  } link_result_t;

  // Settings as last written.
  logic [15:0] speed_set;
  logic [15:0] poll_ticks;
  logic [15:0] reply_ticks;
  logic [3:0]  resend_limit;

  // Sequencer state of the predicted engine.
  mlce_pkg::phase_t seq_phase;
  logic [15:0] tick_count;
  logic [3:0]  resend_count;
  logic [7:0]  frame_dir;
  logic [7:0]  frame_spd;
  logic [7:0]  err_code;

  link_result_t pending_link_results[$];
  int           mismatch_count = 0;

  assign failures = mismatch_count;

  // Speed byte of a drive frame: the setting divided by ten, saturated.
  function automatic logic [7:0] speed_byte();
    logic [15:0] tenths;
    tenths = speed_set / 16'd10;
    return (tenths > 16'(mlce_pkg::SPEED_MAX)) ? mlce_pkg::SPEED_MAX : tenths[7:0];
  endfunction

  // A wait ends once the counter has reached its limit; until then it counts.
  function automatic logic wait_over(input logic [15:0] limit_ticks);
    if (tick_count >= limit_ticks) return 1'b1;
    if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
    return 1'b0;
  endfunction

  // Maps a reply status onto the error code; true when the status means ok.
  function automatic logic status_fine(input logic [7:0] st);
    if (st == mlce_pkg::STATUS_OK || st == mlce_pkg::STATUS_IDLE) return 1'b1;
    if (st[0]) err_code = mlce_pkg::ERR_OVERCUR;
    else if (st[1]) err_code = mlce_pkg::ERR_HALL;
    else err_code = mlce_pkg::ERR_OTHER | st;
    return 1'b0;
  endfunction

  // Advances the predicted engine by one tick and returns what it sends.
  task automatic predict_link_result(input link_tick_t t, output link_result_t res);
    logic reply_sound;
    logic drives_run;
    reply_sound = (t.byte0 == mlce_pkg::REPLY_HEADER) && (t.byte3 == (t.byte1 ^ t.byte2));
    res = '0;

    // A request overrides whatever the sequence was doing.
    case (t.cmd)
      mlce_pkg::CMD_BACK: begin
        seq_phase = mlce_pkg::PH_SEND_BACK;
        resend_count = '0;
      end
      mlce_pkg::CMD_FWD: begin
        seq_phase = mlce_pkg::PH_SEND_FWD;
        resend_count = '0;
      end
      mlce_pkg::CMD_STOP: begin
        seq_phase = mlce_pkg::PH_SEND_STOP;
        resend_count = '0;
      end
      mlce_pkg::CMD_SPEED: begin
        seq_phase = mlce_pkg::PH_SEND_SPEED;
        resend_count = '0;
      end
      default: ;
    endcase

    case (seq_phase)
      mlce_pkg::PH_IDLE_START: begin
        tick_count = '0;
        seq_phase = mlce_pkg::PH_IDLE_WAIT;
      end
      mlce_pkg::PH_IDLE_WAIT: begin
        if (wait_over(poll_ticks)) seq_phase = mlce_pkg::PH_SEND_POLL;
      end
      mlce_pkg::PH_SEND_BACK, mlce_pkg::PH_SEND_STOP, mlce_pkg::PH_SEND_POLL,
      mlce_pkg::PH_SEND_FWD, mlce_pkg::PH_SEND_SPEED: begin
        case (seq_phase)
          mlce_pkg::PH_SEND_BACK: begin
            frame_dir = mlce_pkg::DIR_BACK;
            frame_spd = speed_byte();
          end
          mlce_pkg::PH_SEND_FWD: begin
            frame_dir = mlce_pkg::DIR_FWD;
            frame_spd = speed_byte();
          end
          mlce_pkg::PH_SEND_STOP: frame_spd = '0;
          mlce_pkg::PH_SEND_SPEED: frame_spd = speed_byte();
          default: ;
        endcase
        res.tx_valid = 1'b1;
        res.rx_clear = 1'b1;
        res.tx_frame = {frame_dir ^ frame_spd, 32'd0, frame_spd, frame_dir,
                        mlce_pkg::DRIVE_HEADER};
        tick_count = '0;
        seq_phase = mlce_pkg::phase_t'(seq_phase + 4'd1);
      end
      // A poll reply of four or more bytes is checked, a shorter one is a loss.
      mlce_pkg::PH_WAIT_POLL: begin
        if (wait_over(reply_ticks)) begin
          if (t.count >= REPLY_LEN) begin
            if (reply_sound) begin
              if (status_fine(t.byte2)) err_code = mlce_pkg::ERR_NONE;
            end
          end else begin
            err_code = mlce_pkg::ERR_NO_REPLY;
          end
          seq_phase = mlce_pkg::PH_IDLE_START;
        end
      end
      // A command reply must be exactly four bytes, otherwise it is resent until the resend limit is used up.
      mlce_pkg::PH_WAIT_BACK, mlce_pkg::PH_WAIT_STOP, mlce_pkg::PH_WAIT_FWD,
      mlce_pkg::PH_WAIT_SPEED: begin
        if (wait_over(reply_ticks)) begin
          drives_run = (seq_phase != mlce_pkg::PH_WAIT_SPEED);
          if (t.count == REPLY_LEN) begin
            if (reply_sound) begin
              if (status_fine(t.byte2)) begin
                if (drives_run) begin
                  res.tx_valid = 1'b1;
                  res.tx_frame = mlce_pkg::RUN_FRAME;
                end
              end
            end
            seq_phase = mlce_pkg::PH_IDLE_START;
          end else if (resend_count < resend_limit) begin
            resend_count = resend_count + 4'd1;
            seq_phase = mlce_pkg::phase_t'(seq_phase - 4'd1);
          end else begin
            seq_phase = mlce_pkg::PH_IDLE_START;
            if (drives_run) begin
              res.tx_valid = 1'b1;
              res.tx_frame = mlce_pkg::RUN_FRAME;
            end
          end
        end
      end
      default: seq_phase = mlce_pkg::PH_IDLE_START;
    endcase

    res.link_error = err_code;
  endtask

  task automatic flag_field(input string field, input logic [63:0] want_v,
                            input logic [63:0] got_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("checker: %s mismatch at %0t: expected %h, got %h",
               field, $time, want_v, got_v);
  endtask

  // Every edge: settings first, then the result leaving, then the tick entering.
  always @(posedge clk) begin : watch
    link_result_t want;
    link_result_t got;
    link_result_t next_res;
    if (!rst_n) begin
      speed_set    = '0;
      poll_ticks   = mlce_pkg::POLL_INTERVAL_RST;
      reply_ticks  = mlce_pkg::REPLY_WAIT_RST;
      resend_limit = mlce_pkg::RETRY_LIMIT_RST;
      seq_phase    = mlce_pkg::PH_IDLE_START;
      tick_count   = '0;
      resend_count = '0;
      frame_dir    = mlce_pkg::DIRECTION_RST;
      frame_spd    = mlce_pkg::SPEED_RST;
      err_code     = mlce_pkg::ERR_NONE;
      pending_link_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mlce_pkg::REG_SPEED_SETTING: speed_set = cfg_wdata;
          mlce_pkg::REG_POLL_INTERVAL: poll_ticks = cfg_wdata;
          mlce_pkg::REG_REPLY_WAIT:    reply_ticks = cfg_wdata;
          mlce_pkg::REG_RETRY_LIMIT:   resend_limit = cfg_wdata[3:0];
          default: ;
        endcase
      end

      if (out_tvalid && out_tready) begin
        got = out_tdata[73:0];
        if (pending_link_results.size() == 0) begin
          flag_field("result with nothing expected", '0, out_tdata[63:0]);
        end else begin
          want = pending_link_results.pop_front();
          if (got.tx_valid !== want.tx_valid)
            flag_field("tx_valid", 64'(want.tx_valid), 64'(got.tx_valid));
          if (got.tx_frame !== want.tx_frame)
            flag_field("tx_frame", want.tx_frame, got.tx_frame);
          if (got.rx_clear !== want.rx_clear)
            flag_field("rx_clear", 64'(want.rx_clear), 64'(got.rx_clear));
          if (got.link_error !== want.link_error)
            flag_field("link_error", 64'(want.link_error), 64'(got.link_error));
          if (out_tdata[79:74] !== '0)
            flag_field("zero fill", '0, 64'(out_tdata[79:74]));
        end
      end

      if (in_tvalid && in_tready) begin
        predict_link_result(in_tdata[42:0], next_res);
        pending_link_results.push_back(next_res);
      end
    end
    outstanding <= pending_link_results.size();
  end

endmodule

>>> test/tb_motor_link_command_engine.sv
// Testbench top for the belt motor link command engine: clock, reset, stimulus
// and verdict. Depends on mlce_pkg, the engine and motor_link_checker.
module tb_motor_link_command_engine;

  localparam int         HALF_PERIOD  = 4;
  localparam int         RESET_CYCLES = 5;
  localparam int         LIMIT_CYCLES = 300000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         PHASE_ITEMS  = 130;
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic [7:0] REPLY_LEN       = 8'd4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;

  int failures;
  int outstanding;
  int cycle_count = 0;

  // Traffic shape of the current phase.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int cmd_pct = 6;
  int reply_ok_pct = 60;
  int hold_requests = 0;
  int holds_done = 0;

  always #HALF_PERIOD clk = ~clk;

  motor_link_command_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  motor_link_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when the stimulus asks.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Offers one tick, with random idle cycles first, and waits for the transaction.
  task automatic offer_tick(input logic [2:0] cmd, input logic [7:0] cnt,
                            input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, b3, b2, b1, b0, cnt, cmd};
    do @(posedge clk); while (!in_tready);
  endtask

  // A tick carrying a well-formed reply with the given status.
  task automatic offer_reply(input logic [2:0] cmd, input logic [7:0] cnt,
                             input logic [7:0] status);
    logic [7:0] b1;
    b1 = 8'($urandom);
    offer_tick(cmd, cnt, mlce_pkg::REPLY_HEADER, b1, status, b1 ^ status);
  endtask

  // A random tick: mostly no request and a sound reply, the rest noise.
  task automatic offer_random_tick();
    logic [2:0] cmd;
    logic [7:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] st;
    logic [7:0] b3;
    int pick;
    pick = $urandom_range(99);
    if (pick < cmd_pct) cmd = 3'($urandom_range(mlce_pkg::CMD_SPEED, mlce_pkg::CMD_BACK));
    else if (pick < cmd_pct + 2) cmd = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    else cmd = mlce_pkg::CMD_NONE;

    if ($urandom_range(99) < reply_ok_pct) cnt = REPLY_LEN;
    else if ($urandom_range(1) == 0) cnt = 8'($urandom_range(REPLY_LEN + 2));
    else cnt = 8'($urandom_range(255));

    case ($urandom_range(5))
      0: st = mlce_pkg::STATUS_OK;
      1: st = mlce_pkg::STATUS_IDLE;
      2: st = 8'($urandom) | 8'h01;
      3: st = (8'($urandom) & 8'hFC) | 8'h02;
      4: st = 8'($urandom) & 8'hFC;
      default: st = 8'($urandom);
    endcase

    b0 = ($urandom_range(9) == 0) ? 8'($urandom) : mlce_pkg::REPLY_HEADER;
    b1 = 8'($urandom);
    b3 = ($urandom_range(9) == 0) ? 8'($urandom) : (b1 ^ st);
    offer_tick(cmd, cnt, b0, b1, st, b3);
  endtask

  // Settings change only once every expected result has come back.
  task automatic write_settings(input logic [15:0] spd, input logic [15:0] poll,
                                input logic [15:0] rwait, input logic [3:0] limit);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= mlce_pkg::REG_SPEED_SETTING;
    cfg_wdata <= spd;
    @(posedge clk);
    cfg_index <= mlce_pkg::REG_POLL_INTERVAL;
    cfg_wdata <= poll;
    @(posedge clk);
    cfg_index <= mlce_pkg::REG_REPLY_WAIT;
    cfg_wdata <= rwait;
    @(posedge clk);
    cfg_index <= mlce_pkg::REG_RETRY_LIMIT;
    cfg_wdata <= {12'd0, limit};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] spd, input logic [15:0] poll,
                           input logic [15:0] rwait, input logic [3:0] limit,
                           input int ok_pct, input int req_pct,
                           input int idle_pct, input int stall_pct, input bit hold);
    write_settings(spd, poll, rwait, limit);
    reply_ok_pct       = ok_pct;
    cmd_pct            = req_pct;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    if (hold) hold_requests++;
    repeat (PHASE_ITEMS) offer_random_tick();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks: a lost poll reply, then each request with its reply cases.
    write_settings(16'd0, 16'd1, 16'd1, 4'd0);
    offer_tick(mlce_pkg::CMD_NONE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_tick(mlce_pkg::CMD_NONE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_tick(mlce_pkg::CMD_NONE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_tick(mlce_pkg::CMD_NONE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_tick(mlce_pkg::CMD_NONE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_tick(mlce_pkg::CMD_NONE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_tick(mlce_pkg::CMD_BACK, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    offer_tick(mlce_pkg::CMD_NONE, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    offer_reply(mlce_pkg::CMD_NONE, REPLY_LEN, mlce_pkg::STATUS_OK);
    offer_tick(mlce_pkg::CMD_FWD, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_tick(mlce_pkg::CMD_NONE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_reply(mlce_pkg::CMD_NONE, REPLY_LEN, mlce_pkg::ERR_OVERCUR);
    offer_tick(mlce_pkg::CMD_STOP, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_tick(mlce_pkg::CMD_NONE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_reply(mlce_pkg::CMD_NONE, REPLY_LEN, 8'h02);
    offer_tick(mlce_pkg::CMD_SPEED, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_tick(mlce_pkg::CMD_NONE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_reply(mlce_pkg::CMD_NONE, REPLY_LEN, mlce_pkg::STATUS_IDLE);
    offer_tick(mlce_pkg::CMD_BACK, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_tick(mlce_pkg::CMD_NONE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_reply(mlce_pkg::CMD_NONE, 8'd3, mlce_pkg::STATUS_OK);
    offer_tick(CMD_SPARE_LAST, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_tick(mlce_pkg::CMD_FWD, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_tick(mlce_pkg::CMD_NONE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_reply(mlce_pkg::CMD_NONE, REPLY_LEN, 8'h84);

    // Random phases over a spread of settings and traffic shapes.
    run_phase(16'hFFFF, 16'd3, 16'd2, 4'd15, 5, 5, 0, 0, 1'b0);
    run_phase(16'd1279, 16'd1, 16'd1, 4'd1, 60, 6, 69, 0, 1'b0);
    run_phase(16'($urandom), 16'($urandom_range(6, 1)), 16'($urandom_range(5, 1)),
              4'($urandom_range(15)), 60, 6, 0, 69, 1'b0);
    run_phase(16'd9, 16'hFFFF, 16'hFFFF, 4'd0, 60, 10, 20, 20, 1'b0);
    run_phase(16'd1270, 16'd2, 16'd3, 4'd3, 70, 4, 0, 0, 1'b1);
    run_phase(16'($urandom), 16'($urandom_range(8, 1)), 16'($urandom_range(8, 1)),
              4'($urandom_range(15)), 50, 6, 69, 0, 1'b0);
    run_phase(16'd10, 16'd5, 16'd1, 4'd2, 60, 6, 0, 69, 1'b0);

    // Let every result drain, then give the verdict.
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/mlce_pkg.sv
sv/motor_link_command_engine.sv
test/motor_link_checker.sv
test/tb_motor_link_command_engine.sv
